// ===== design/bkt_pkg.sv =====
// Shared types, field widths and request codes for the bounded time-keyed table.
package bkt_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int KEY_W     = 64;
    localparam int WDATA_W   = 32;
    localparam int RDATA_W   = 32;
    localparam int REQ_W     = 2;
    localparam int CFG_W     = 5;
    localparam int SLOT_W    = 4;
    localparam int ENTRIES_W = 5;

    localparam int S_TDATA_W = KEY_W + WDATA_W;
    localparam int M_FIELD_W = RDATA_W + SLOT_W + ENTRIES_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_STORE  = 2'd1,
        REQ_CLAIM  = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    // Search results carried from one cell to the next.
    typedef struct packed {
        logic match;
        logic free;
        logic min_ok;
    } carry_flags_t;

    // Update broadcast to all cells; only the addressed cell acts on an update, while clear_all acts on every cell.
    typedef struct packed {
        logic clear_all;
        logic update;
        logic set_valid;
        logic write_data;
    } cell_cmd_t;

endpackage

// ===== design/bkt_cell.sv =====
// One slot of the table plus its stage of the search chain.
module bkt_cell #(
    parameter int CELL_IDX   = 0,
    parameter int IDX_W      = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [bkt_pkg::KEY_W-1:0]  req_key,
    input  bkt_pkg::cell_cmd_t         cmd,
    input  logic [IDX_W-1:0]           cmd_idx,
    input  logic [DATA_WIDTH-1:0]      cmd_data,
    input  bkt_pkg::carry_flags_t      flags_in,
    input  logic [IDX_W-1:0]           match_idx_in,
    input  logic [DATA_WIDTH-1:0]      match_data_in,
    input  logic [IDX_W-1:0]           free_idx_in,
    input  logic [IDX_W-1:0]           min_idx_in,
    input  logic [bkt_pkg::KEY_W-1:0]  min_key_in,
    input  logic [DATA_WIDTH-1:0]      min_data_in,
    output bkt_pkg::carry_flags_t      flags_out,
    output logic [IDX_W-1:0]           match_idx_out,
    output logic [DATA_WIDTH-1:0]      match_data_out,
    output logic [IDX_W-1:0]           free_idx_out,
    output logic [IDX_W-1:0]           min_idx_out,
    output logic [bkt_pkg::KEY_W-1:0]  min_key_out,
    output logic [DATA_WIDTH-1:0]      min_data_out
);
    import bkt_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                  valid_reg, valid_next;
    logic [KEY_W-1:0]      key_reg;
    logic [DATA_WIDTH-1:0] data_reg;

    carry_flags_t          flags_reg, flags_next;
    logic [IDX_W-1:0]      match_idx_reg, match_idx_next;
    logic [DATA_WIDTH-1:0] match_data_reg, match_data_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]      min_idx_reg, min_idx_next;
    logic [KEY_W-1:0]      min_key_reg, min_key_next;
    logic [DATA_WIDTH-1:0] min_data_reg, min_data_next;

    logic sel;
    logic is_match;
    logic is_less;

    assign sel = cmd.update && (cmd_idx == MY_IDX);

    always_comb begin
        valid_next = valid_reg;
        if (cmd.clear_all) begin
            valid_next = 1'b0;
        end else if (sel && cmd.set_valid) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sel) begin
            key_reg <= req_key;
        end
        if (sel && cmd.write_data) begin
            data_reg <= cmd_data;
        end
    end

    // Ties on the minimum keep the earlier, lower-index slot.
    assign is_match = valid_reg && (key_reg == req_key);
    assign is_less  = valid_reg &&
                      (!flags_in.min_ok || ($signed(key_reg) < $signed(min_key_in)));

    always_comb begin
        flags_next      = flags_in;
        match_idx_next  = match_idx_in;
        match_data_next = match_data_in;
        free_idx_next   = free_idx_in;
        min_idx_next    = min_idx_in;
        min_key_next    = min_key_in;
        min_data_next   = min_data_in;
        if (!flags_in.match && is_match) begin
            flags_next.match = 1'b1;
            match_idx_next   = MY_IDX;
            match_data_next  = data_reg;
        end
        if (!flags_in.free && !valid_reg) begin
            flags_next.free = 1'b1;
            free_idx_next   = MY_IDX;
        end
        if (is_less) begin
            flags_next.min_ok = 1'b1;
            min_idx_next      = MY_IDX;
            min_key_next      = key_reg;
            min_data_next     = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        flags_reg      <= flags_next;
        match_idx_reg  <= match_idx_next;
        match_data_reg <= match_data_next;
        free_idx_reg   <= free_idx_next;
        min_idx_reg    <= min_idx_next;
        min_key_reg    <= min_key_next;
        min_data_reg   <= min_data_next;
    end

    assign flags_out      = flags_reg;
    assign match_idx_out  = match_idx_reg;
    assign match_data_out = match_data_reg;
    assign free_idx_out   = free_idx_reg;
    assign min_idx_out    = min_idx_reg;
    assign min_key_out    = min_key_reg;
    assign min_data_out   = min_data_reg;

endmodule

// ===== design/bounded_time_keyed_table_top.sv =====
// Top level of the bounded time-keyed table: request control, limit and result register.
// The table holds CAPACITY slots, each a signed 64-bit key, a data word and a valid bit,
// laid out as a row of cells. An accepted item walks down the row one cell per cycle,
// picking up the matching slot, the first free slot and the smallest valid key; after
// the last cell, once the output register is free, the slot is updated and the result
// registered; only then is the next item accepted, so the table works on one item at a
// time. A finished result waits in the output register while the next
// item is already taken. A miss on store or claim takes the lowest free slot while the
// table holds fewer than max_entries entries, and otherwise recycles the smallest key.
// max_entries of 0 acts as 1 and values above CAPACITY act as CAPACITY; write it only
// while the block is idle, and only after a clear.
module bounded_time_keyed_table_top #(
    parameter int CAPACITY   = bkt_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = bkt_pkg::DEF_DATA_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [bkt_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // key [63:0], write_data [95:64]
    input  logic [bkt_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type [1:0]
    input  logic [bkt_pkg::REQ_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_data [31:0], slot [35:32], entries [40:36], zero padding above
    output logic [bkt_pkg::M_TDATA_W-1:0] m_tdata,
    // hit [0]
    output logic [0:0]                    m_tuser
);
    import bkt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      sweep_cnt_reg, sweep_cnt_next;
    req_t                  req_type_reg;
    logic [KEY_W-1:0]      req_key_reg;
    logic [DATA_WIDTH-1:0] req_wdata_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CFG_W-1:0]      max_entries_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic accept;
    logic out_free;
    logic done;
    logic room;

    carry_flags_t          flags_c      [0:CAPACITY];
    logic [IDX_W-1:0]      match_idx_c  [0:CAPACITY];
    logic [DATA_WIDTH-1:0] match_data_c [0:CAPACITY];
    logic [IDX_W-1:0]      free_idx_c   [0:CAPACITY];
    logic [IDX_W-1:0]      min_idx_c    [0:CAPACITY];
    logic [KEY_W-1:0]      min_key_c    [0:CAPACITY];
    logic [DATA_WIDTH-1:0] min_data_c   [0:CAPACITY];

    cell_cmd_t             cmd, cmd_apply;
    logic [IDX_W-1:0]      cmd_idx;
    logic [DATA_WIDTH-1:0] cmd_data;
    logic                  hit;
    logic [DATA_WIDTH-1:0] rd;
    logic [IDX_W-1:0]      slot_idx;
    logic [CNT_W-1:0]      count_upd;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign done     = (state_reg == ST_SWEEP) && (sweep_cnt_reg == CAP_CNT) && out_free;

    // Chain of slot cells; the head starts with nothing found.
    assign flags_c[0]      = '0;
    assign match_idx_c[0]  = '0;
    assign match_data_c[0] = '0;
    assign free_idx_c[0]   = '0;
    assign min_idx_c[0]    = '0;
    assign min_key_c[0]    = '0;
    assign min_data_c[0]   = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bkt_cell #(
            .CELL_IDX   (g),
            .IDX_W      (IDX_W),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .req_key        (req_key_reg),
            .cmd            (cmd_apply),
            .cmd_idx        (cmd_idx),
            .cmd_data       (cmd_data),
            .flags_in       (flags_c[g]),
            .match_idx_in   (match_idx_c[g]),
            .match_data_in  (match_data_c[g]),
            .free_idx_in    (free_idx_c[g]),
            .min_idx_in     (min_idx_c[g]),
            .min_key_in     (min_key_c[g]),
            .min_data_in    (min_data_c[g]),
            .flags_out      (flags_c[g+1]),
            .match_idx_out  (match_idx_c[g+1]),
            .match_data_out (match_data_c[g+1]),
            .free_idx_out   (free_idx_c[g+1]),
            .min_idx_out    (min_idx_c[g+1]),
            .min_key_out    (min_key_c[g+1]),
            .min_data_out   (min_data_c[g+1])
        );
    end

    // Room for a new entry: count below the limit saturated into 1..CAPACITY.
    always_comb begin
        if (max_entries_reg == '0) begin
            room = (count_reg == '0);
        end else begin
            room = (CMP_W'(count_reg) < CMP_W'(max_entries_reg)) && (count_reg != CAP_CNT);
        end
    end

    always_comb begin
        cmd       = '0;
        cmd_idx   = '0;
        cmd_data  = req_wdata_reg;
        hit       = 1'b0;
        rd        = '0;
        slot_idx  = '0;
        count_upd = count_reg;
        unique case (req_type_reg)
            REQ_LOOKUP: begin
                if (flags_c[CAPACITY].match) begin
                    hit      = 1'b1;
                    rd       = match_data_c[CAPACITY];
                    slot_idx = match_idx_c[CAPACITY];
                end
            end
            REQ_STORE, REQ_CLAIM: begin
                if (flags_c[CAPACITY].match) begin
                    hit      = 1'b1;
                    slot_idx = match_idx_c[CAPACITY];
                    if (req_type_reg == REQ_STORE) begin
                        cmd.update     = 1'b1;
                        cmd.write_data = 1'b1;
                        cmd_idx        = match_idx_c[CAPACITY];
                    end else begin
                        rd = match_data_c[CAPACITY];
                    end
                end else if (room && flags_c[CAPACITY].free) begin
                    slot_idx       = free_idx_c[CAPACITY];
                    cmd.update     = 1'b1;
                    cmd.set_valid  = 1'b1;
                    cmd.write_data = 1'b1;
                    cmd_idx        = free_idx_c[CAPACITY];
                    if (req_type_reg == REQ_CLAIM) begin
                        cmd_data = '0;
                    end
                    count_upd = count_reg + 1'b1;
                end else if (flags_c[CAPACITY].min_ok) begin
                    // Recycle the smallest key; a claim keeps and returns the old data.
                    slot_idx   = min_idx_c[CAPACITY];
                    cmd.update = 1'b1;
                    cmd_idx    = min_idx_c[CAPACITY];
                    if (req_type_reg == REQ_STORE) begin
                        cmd.write_data = 1'b1;
                    end else begin
                        rd = min_data_c[CAPACITY];
                    end
                end else begin
                    // Full with no valid slot cannot arise from a consistent count;
                    // fall back to the free slot, or slot zero, as a fresh entry.
                    slot_idx       = flags_c[CAPACITY].free ? free_idx_c[CAPACITY] : '0;
                    cmd.update     = 1'b1;
                    cmd.set_valid  = 1'b1;
                    cmd.write_data = 1'b1;
                    cmd_idx        = slot_idx;
                    if (req_type_reg == REQ_CLAIM) begin
                        cmd_data = '0;
                    end
                    count_upd = count_reg + 1'b1;
                end
            end
            REQ_CLEAR: begin
                cmd.clear_all = 1'b1;
                count_upd     = '0;
            end
        endcase
    end

    assign cmd_apply  = done ? cmd : '0;
    assign count_next = done ? count_upd : count_reg;

    always_comb begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next     = ST_SWEEP;
                    sweep_cnt_next = '0;
                end
            end
            ST_SWEEP: begin
                if (done) begin
                    state_next = ST_IDLE;
                end else if (sweep_cnt_reg != CAP_CNT) begin
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (done) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{M_PAD_W{1'b0}}, ENTRIES_W'(count_upd), SLOT_W'(slot_idx),
                             RDATA_W'(rd)};
            m_tuser_next  = hit;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            sweep_cnt_reg   <= '0;
            count_reg       <= '0;
            max_entries_reg <= MAX_ENTRIES_RST;
            m_tvalid_reg    <= 1'b0;
            req_type_reg    <= REQ_LOOKUP;
        end else begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            count_reg     <= count_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_wen) begin
                max_entries_reg <= cfg_wdata;
            end
            if (accept) begin
                req_type_reg <= req_t'(s_tuser);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_key_reg   <= s_tdata[KEY_W-1:0];
            req_wdata_reg <= DATA_WIDTH'(s_tdata[KEY_W +: WDATA_W]);
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
